>>> design/generational_slot_work_queue_assert.svh
// Assertion shorthands for the work queue checker.
`ifndef GENERATIONAL_SLOT_WORK_QUEUE_ASSERT_SVH
`define GENERATIONAL_SLOT_WORK_QUEUE_ASSERT_SVH

// Condition that holds at every clock edge out of reset.
`define GSWQ_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition in one cycle that implies another in the next cycle.
`define GSWQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/gswq_pkg.sv
`default_nettype none

package gswq_pkg;

    localparam int SLOT_COUNT_DEFAULT    = 8;
    localparam int PRIORITY_BITS_DEFAULT = 8;

    localparam int CMD_W    = 3;
    localparam int STATUS_W = 3;
    localparam int TAG_W    = 32;
    localparam int GEN_W    = 32;
    localparam int HSLOT_W  = 8;
    localparam int COUNT_W  = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_SUBMIT   = 3'd0,
        CMD_CANCEL   = 3'd1,
        CMD_QUERY    = 3'd2,
        CMD_DISPATCH = 3'd3,
        CMD_COMPLETE = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK            = 3'd0,
        STATUS_NO_ROOM       = 3'd1,
        STATUS_INVALID_ARG   = 3'd2,
        STATUS_NOT_FOUND     = 3'd3,
        STATUS_INVALID_STATE = 3'd4,
        STATUS_FIFO_EMPTY    = 3'd5,
        STATUS_STALE_ENTRY   = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        SLOT_FREE    = 2'd0,
        SLOT_QUEUED  = 2'd1,
        SLOT_RUNNING = 2'd2
    } slot_state_t;

endpackage

`default_nettype wire

>>> design/generational_slot_work_queue.sv
// Job table of SLOT_COUNT slots with generation-tagged handles and an in-order dispatch queue.
// Each command (submit, cancel, query, dispatch, complete) is one item and gives one result
// item carrying status, handle or job fields and the table counters after the command. The
// block takes one item per clock while out_ready does not hold results back: an input
// register, then the free-slot search, handle check, queue pop and table update as
// combinational logic, then the result register. Results hold while out_ready is low and
// the block keeps one further item in its input register meanwhile.
`default_nettype none

module generational_slot_work_queue #(
    parameter int SLOT_COUNT    = gswq_pkg::SLOT_COUNT_DEFAULT,
    parameter int PRIORITY_BITS = gswq_pkg::PRIORITY_BITS_DEFAULT,
    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1,
    localparam int IDX_W  = $clog2(SLOT_COUNT + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [gswq_pkg::CMD_W-1:0]    command,
    input  wire logic [gswq_pkg::TAG_W-1:0]    work_tag,
    input  wire logic [PRIORITY_BITS-1:0]      job_priority,
    input  wire logic [gswq_pkg::HSLOT_W-1:0]  handle_slot,
    input  wire logic [gswq_pkg::GEN_W-1:0]    handle_generation,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [gswq_pkg::STATUS_W-1:0]      status,
    output logic [IDX_W-1:0]                   slot_index,
    output logic [gswq_pkg::GEN_W-1:0]         generation_out,
    output logic [PRIORITY_BITS-1:0]           priority_out,
    output logic [gswq_pkg::TAG_W-1:0]         tag_out,
    output logic                               active,
    output logic [IDX_W-1:0]                   queued_count,
    output logic                               running,
    output logic [gswq_pkg::COUNT_W-1:0]       submitted_count,
    output logic [gswq_pkg::COUNT_W-1:0]       completed_count,
    output logic [gswq_pkg::COUNT_W-1:0]       cancelled_count,
    output logic [gswq_pkg::COUNT_W-1:0]       rejected_count
);

    localparam logic [IDX_W-1:0]  NONE     = IDX_W'(SLOT_COUNT);
    localparam logic [SLOT_W-1:0] LAST_PTR = SLOT_W'(SLOT_COUNT - 1);

    logic                            in_valid_reg;
    logic [gswq_pkg::CMD_W-1:0]      command_reg;
    logic [gswq_pkg::TAG_W-1:0]      work_tag_reg;
    logic [PRIORITY_BITS-1:0]        priority_reg;
    logic [gswq_pkg::HSLOT_W-1:0]    hslot_reg;
    logic [gswq_pkg::GEN_W-1:0]      hgen_reg;

    gswq_pkg::slot_state_t           slot_state_reg [SLOT_COUNT];
    logic [gswq_pkg::GEN_W-1:0]      slot_gen_reg   [SLOT_COUNT];
    logic [PRIORITY_BITS-1:0]        slot_prio_reg  [SLOT_COUNT];
    logic [gswq_pkg::TAG_W-1:0]      slot_tag_reg   [SLOT_COUNT];
    logic [SLOT_W-1:0]               fifo_slot_reg  [SLOT_COUNT];
    logic [gswq_pkg::GEN_W-1:0]      fifo_gen_reg   [SLOT_COUNT];

    logic [gswq_pkg::GEN_W-1:0]      gen_counter_reg;
    logic [SLOT_W-1:0]               rd_ptr_reg;
    logic [SLOT_W-1:0]               wr_ptr_reg;
    logic [IDX_W-1:0]                fifo_count_reg;
    logic [IDX_W-1:0]                cur_slot_reg;
    logic [IDX_W-1:0]                queued_reg;
    logic [gswq_pkg::COUNT_W-1:0]    submit_cnt_reg;
    logic [gswq_pkg::COUNT_W-1:0]    complete_cnt_reg;
    logic [gswq_pkg::COUNT_W-1:0]    cancel_cnt_reg;
    logic [gswq_pkg::COUNT_W-1:0]    reject_cnt_reg;

    logic                            out_valid_reg;
    gswq_pkg::status_t               status_reg;
    logic [IDX_W-1:0]                slot_index_reg;
    logic [gswq_pkg::GEN_W-1:0]      gen_out_reg;
    logic [PRIORITY_BITS-1:0]        prio_out_reg;
    logic [gswq_pkg::TAG_W-1:0]      tag_out_reg;
    logic                            active_reg;

    logic                            out_open;
    logic                            go;
    logic                            in_fire;

    logic                            free_found;
    logic [SLOT_W-1:0]               free_idx;
    logic [SLOT_W-1:0]               rd_idx;
    gswq_pkg::slot_state_t           rd_state;
    logic [gswq_pkg::GEN_W-1:0]      rd_gen;
    logic [gswq_pkg::GEN_W-1:0]      gen_new;
    logic                            hvalid;
    logic                            fifo_full;
    logic                            cur_busy;

    gswq_pkg::status_t               res_status;
    logic [IDX_W-1:0]                res_slot;
    logic [gswq_pkg::GEN_W-1:0]      res_gen;
    logic [PRIORITY_BITS-1:0]        res_prio;
    logic [gswq_pkg::TAG_W-1:0]      res_tag;
    logic                            res_active;
    logic                            st_we;
    logic [SLOT_W-1:0]               st_idx;
    gswq_pkg::slot_state_t           st_val;
    logic                            gen_we;
    logic                            job_we;
    logic                            fifo_push;
    logic                            fifo_pop;
    logic [IDX_W-1:0]                cur_slot_next;
    logic                            queued_inc;
    logic                            queued_dec;
    logic                            cnt_submit;
    logic                            cnt_complete;
    logic                            cnt_cancel;
    logic                            cnt_reject;

    assign out_open = !out_valid_reg || out_ready;
    assign go       = in_valid_reg && out_open;
    assign in_ready = !in_valid_reg || out_open;
    assign in_fire  = in_valid && in_ready;

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (slot_state_reg[i] == gswq_pkg::SLOT_FREE)
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        case (command_reg)
            gswq_pkg::CMD_DISPATCH: rd_idx = fifo_slot_reg[rd_ptr_reg];
            gswq_pkg::CMD_COMPLETE: rd_idx = cur_slot_reg[SLOT_W-1:0];
            default:                rd_idx = hslot_reg[SLOT_W-1:0];
        endcase
    end

    assign rd_state  = slot_state_reg[rd_idx];
    assign rd_gen    = slot_gen_reg[rd_idx];
    assign gen_new   = (gen_counter_reg == '1) ? gswq_pkg::GEN_W'(1)
                                               : gen_counter_reg + 1'b1;
    assign hvalid    = (hslot_reg < gswq_pkg::HSLOT_W'(SLOT_COUNT)) && (hgen_reg != '0);
    assign fifo_full = fifo_count_reg == IDX_W'(SLOT_COUNT);
    assign cur_busy  = cur_slot_reg != NONE;

    always_comb
    begin
        res_status    = gswq_pkg::STATUS_OK;
        res_slot      = NONE;
        res_gen       = '0;
        res_prio      = '0;
        res_tag       = '0;
        res_active    = 1'b0;
        st_we         = 1'b0;
        st_idx        = rd_idx;
        st_val        = gswq_pkg::SLOT_FREE;
        gen_we        = 1'b0;
        job_we        = 1'b0;
        fifo_push     = 1'b0;
        fifo_pop      = 1'b0;
        cur_slot_next = cur_slot_reg;
        queued_inc    = 1'b0;
        queued_dec    = 1'b0;
        cnt_submit    = 1'b0;
        cnt_complete  = 1'b0;
        cnt_cancel    = 1'b0;
        cnt_reject    = 1'b0;
        case (command_reg)
            gswq_pkg::CMD_SUBMIT:
            begin
                if (work_tag_reg == '0)
                begin
                    res_status = gswq_pkg::STATUS_INVALID_ARG;
                end
                else if (!free_found)
                begin
                    res_status = gswq_pkg::STATUS_NO_ROOM;
                    cnt_reject = 1'b1;
                end
                else
                begin
                    // stamp the slot even when the queue turns it away
                    gen_we = 1'b1;
                    st_idx = free_idx;
                    if (fifo_full)
                    begin
                        res_status = gswq_pkg::STATUS_NO_ROOM;
                        cnt_reject = 1'b1;
                    end
                    else
                    begin
                        st_we      = 1'b1;
                        st_val     = gswq_pkg::SLOT_QUEUED;
                        job_we     = 1'b1;
                        fifo_push  = 1'b1;
                        queued_inc = 1'b1;
                        cnt_submit = 1'b1;
                        res_slot   = IDX_W'(free_idx);
                        res_gen    = gen_new;
                    end
                end
            end
            gswq_pkg::CMD_CANCEL:
            begin
                if (!hvalid)
                begin
                    res_status = gswq_pkg::STATUS_INVALID_ARG;
                end
                else if (rd_gen != hgen_reg || rd_state == gswq_pkg::SLOT_FREE)
                begin
                    res_status = gswq_pkg::STATUS_NOT_FOUND;
                end
                else if (rd_state == gswq_pkg::SLOT_QUEUED)
                begin
                    st_we      = 1'b1;
                    queued_dec = 1'b1;
                    cnt_cancel = 1'b1;
                end
                else
                begin
                    res_status = gswq_pkg::STATUS_INVALID_STATE;
                end
            end
            gswq_pkg::CMD_QUERY:
            begin
                res_active = hvalid && rd_gen == hgen_reg && rd_state != gswq_pkg::SLOT_FREE;
            end
            gswq_pkg::CMD_DISPATCH:
            begin
                if (cur_busy)
                begin
                    res_status = gswq_pkg::STATUS_INVALID_STATE;
                end
                else if (fifo_count_reg == '0)
                begin
                    res_status = gswq_pkg::STATUS_FIFO_EMPTY;
                end
                else
                begin
                    fifo_pop = 1'b1;
                    if (rd_state == gswq_pkg::SLOT_QUEUED && rd_gen == fifo_gen_reg[rd_ptr_reg])
                    begin
                        st_we         = 1'b1;
                        st_val        = gswq_pkg::SLOT_RUNNING;
                        queued_dec    = 1'b1;
                        cur_slot_next = IDX_W'(rd_idx);
                        res_slot      = IDX_W'(rd_idx);
                        res_gen       = rd_gen;
                        res_prio      = slot_prio_reg[rd_idx];
                        res_tag       = slot_tag_reg[rd_idx];
                    end
                    else
                    begin
                        res_status = gswq_pkg::STATUS_STALE_ENTRY;
                    end
                end
            end
            gswq_pkg::CMD_COMPLETE:
            begin
                if (!cur_busy)
                begin
                    res_status = gswq_pkg::STATUS_INVALID_STATE;
                end
                else
                begin
                    if (rd_state == gswq_pkg::SLOT_RUNNING)
                    begin
                        st_we        = 1'b1;
                        cnt_complete = 1'b1;
                    end
                    cur_slot_next = NONE;
                end
            end
            default:
            begin
                res_status = gswq_pkg::STATUS_INVALID_ARG;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            gen_counter_reg  <= '0;
            rd_ptr_reg       <= '0;
            wr_ptr_reg       <= '0;
            fifo_count_reg   <= '0;
            cur_slot_reg     <= NONE;
            queued_reg       <= '0;
            submit_cnt_reg   <= '0;
            complete_cnt_reg <= '0;
            cancel_cnt_reg   <= '0;
            reject_cnt_reg   <= '0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slot_state_reg[i] <= gswq_pkg::SLOT_FREE;
            end
        end
        else
        begin
            if (in_fire)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (go)
            begin
                in_valid_reg <= 1'b0;
            end

            if (go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (go)
            begin
                if (st_we)
                begin
                    slot_state_reg[st_idx] <= st_val;
                end
                if (gen_we)
                begin
                    gen_counter_reg <= gen_new;
                end
                if (fifo_push)
                begin
                    wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
                end
                if (fifo_pop)
                begin
                    rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
                end
                if (fifo_push)
                begin
                    fifo_count_reg <= fifo_count_reg + 1'b1;
                end
                else if (fifo_pop)
                begin
                    fifo_count_reg <= fifo_count_reg - 1'b1;
                end
                if (queued_inc)
                begin
                    queued_reg <= queued_reg + 1'b1;
                end
                else if (queued_dec)
                begin
                    queued_reg <= queued_reg - 1'b1;
                end
                cur_slot_reg <= cur_slot_next;
                if (cnt_submit)
                begin
                    submit_cnt_reg <= submit_cnt_reg + 1'b1;
                end
                if (cnt_complete)
                begin
                    complete_cnt_reg <= complete_cnt_reg + 1'b1;
                end
                if (cnt_cancel)
                begin
                    cancel_cnt_reg <= cancel_cnt_reg + 1'b1;
                end
                if (cnt_reject)
                begin
                    reject_cnt_reg <= reject_cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            command_reg  <= command;
            work_tag_reg <= work_tag;
            priority_reg <= job_priority;
            hslot_reg    <= handle_slot;
            hgen_reg     <= handle_generation;
        end
        if (go)
        begin
            status_reg     <= res_status;
            slot_index_reg <= res_slot;
            gen_out_reg    <= res_gen;
            prio_out_reg   <= res_prio;
            tag_out_reg    <= res_tag;
            active_reg     <= res_active;
            if (gen_we)
            begin
                slot_gen_reg[st_idx] <= gen_new;
            end
            if (job_we)
            begin
                slot_prio_reg[st_idx] <= priority_reg;
                slot_tag_reg[st_idx]  <= work_tag_reg;
            end
            if (fifo_push)
            begin
                fifo_slot_reg[wr_ptr_reg] <= st_idx;
                fifo_gen_reg[wr_ptr_reg]  <= gen_new;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign slot_index      = slot_index_reg;
    assign generation_out  = gen_out_reg;
    assign priority_out    = prio_out_reg;
    assign tag_out         = tag_out_reg;
    assign active          = active_reg;
    assign queued_count    = queued_reg;
    assign running         = cur_busy;
    assign submitted_count = submit_cnt_reg;
    assign completed_count = complete_cnt_reg;
    assign cancelled_count = cancel_cnt_reg;
    assign rejected_count  = reject_cnt_reg;

endmodule

`default_nettype wire

>>> design/gswq_checker.sv
`default_nettype none

`include "generational_slot_work_queue_assert.svh"

module gswq_checker #(
    parameter int SLOT_COUNT = gswq_pkg::SLOT_COUNT_DEFAULT,
    localparam int IDX_W     = $clog2(SLOT_COUNT + 1)
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [gswq_pkg::STATUS_W-1:0] status,
    input wire logic [IDX_W-1:0]              slot_index,
    input wire logic [gswq_pkg::GEN_W-1:0]    generation_out,
    input wire logic [IDX_W-1:0]              queued_count,
    input wire logic                          running,
    input wire logic [gswq_pkg::COUNT_W-1:0]  submitted_count
);

    // a running job holds one slot
    `GSWQ_ASSERT_ALWAYS(a_running_slot, !running || queued_count < IDX_W'(SLOT_COUNT), "queued count leaves no slot for the running job")

    // a handle in a result always names a real slot
    `GSWQ_ASSERT_ALWAYS(a_handle_slot, !(out_valid && generation_out != '0) || slot_index < IDX_W'(SLOT_COUNT), "result handle with slot out of range")

    // table state holds while a result waits
    `GSWQ_ASSERT_NEXT(a_state_hold, out_valid && !out_ready, $stable(queued_count) && $stable(running) && $stable(submitted_count), "table state moved under a stalled result")

    `GSWQ_ASSERT_NEXT(a_result_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(generation_out) && $stable(slot_index), "stalled result changed")

endmodule

bind generational_slot_work_queue gswq_checker #(.SLOT_COUNT(SLOT_COUNT)) u_gswq_checker (.*);

`default_nettype wire
